@@ design/pump_tank_relay_controller_assert.svh @@
// Assertion macros shared by the pump and tank relay controller RTL.
`ifndef PUMP_TANK_RELAY_CONTROLLER_ASSERT_SVH
`define PUMP_TANK_RELAY_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PTRC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pump tank relay controller: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define PTRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pump tank relay controller: next-cycle check failed");

`endif

@@ design/ptrc_pkg.sv @@
// Shared types and constants of the pump and tank relay controller.
package ptrc_pkg;

   localparam int ZONE_COUNT = 6;
   localparam int CNT_W      = 16;
   localparam int RELAY_W    = 8;
   localparam int TANK_BIT   = 6;
   localparam int PUMP_BIT   = 7;

   // Zones are limited to bits 0..5; bits 6 and 7 are tank and pump.
   localparam logic [RELAY_W-1:0] ZONE_MASK =
      RELAY_W'(((1 << ZONE_COUNT) - 1) & 32'h3F);

   typedef logic [1:0]         kind_type;
   typedef logic [2:0]         relay_idx_type;
   typedef logic [CNT_W-1:0]   count_type;
   typedef logic [RELAY_W-1:0] relay_vec_type;
   typedef logic [1:0]         csr_idx_type;

   localparam kind_type KIND_TICK    = 2'd0;
   localparam kind_type KIND_TOGGLE  = 2'd1;
   localparam kind_type KIND_ALL_OFF = 2'd2;
   localparam kind_type KIND_UNUSED  = 2'd3;

   localparam csr_idx_type CSR_TANK_AUTO_MODE     = 2'd0;
   localparam csr_idx_type CSR_PUMP_START_DELAY   = 2'd1;
   localparam csr_idx_type CSR_FLOAT_STABLE_TICKS = 2'd2;

   localparam count_type PUMP_START_DELAY_RESET   = 16'd1000;
   localparam count_type FLOAT_STABLE_TICKS_RESET = 16'd500;
   localparam count_type CNT_MAX                  = '1;

endpackage

@@ design/pump_tank_relay_controller.sv @@
// Pump and tank relay controller: tick, toggle and all-off requests drive eight relays.
// A request waits in the request register until the response register can take it.
// Throughput: one request per cycle while rsp_ready is high; a request register and a
// response register separate the two channels, and the state update sits between them.
// Reset: synchronous, active high; relays, sequence flags and counters clear and the
// configuration registers return to auto mode off, start delay 1000, float ticks 500.
`include "pump_tank_relay_controller_assert.svh"

module pump_tank_relay_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  ptrc_pkg::kind_type      req_kind,
   input  ptrc_pkg::relay_idx_type req_relay_index,
   input  logic                    req_float_high,
   input  logic                    req_lockout,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output ptrc_pkg::relay_vec_type rsp_relay_states,
   output logic                    rsp_pump_running,
   output logic                    rsp_tank_wants_water,
   input  logic                    csr_write_en,
   input  ptrc_pkg::csr_idx_type   csr_index,
   input  ptrc_pkg::count_type     csr_wdata
);
   import ptrc_pkg::*;

   // Configuration.
   logic          tank_auto_mode_ff;
   count_type     pump_start_delay_ff;
   count_type     float_stable_ticks_ff;

   // Request register.
   logic          req_valid_ff;
   kind_type      req_kind_ff;
   relay_idx_type req_relay_index_ff;
   logic          req_float_high_ff;
   logic          req_lockout_ff;

   // Controller state.
   relay_vec_type relay_on_ff, relay_on_in;
   logic          pump_started_ff, pump_started_in;
   logic          demand_latched_ff, demand_latched_in;
   logic          tank_mode_seen_ff, tank_mode_seen_in;
   logic          tank_request_ff, tank_request_in;
   count_type     float_high_ticks_ff, float_high_ticks_in;
   count_type     demand_ticks_ff, demand_ticks_in;

   // Response register.
   logic          rsp_valid_ff;
   relay_vec_type rsp_relay_states_ff;
   logic          rsp_pump_running_ff;
   logic          rsp_tank_wants_water_ff;

   logic          advance;

   function automatic count_type sat_inc(input count_type v);
      return (v == CNT_MAX) ? CNT_MAX : count_type'(v + 1'b1);
   endfunction

   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;

   always_comb begin
      logic          want;
      logic          demand;
      relay_vec_type others;
      relay_on_in         = relay_on_ff;
      pump_started_in     = pump_started_ff;
      demand_latched_in   = demand_latched_ff;
      tank_mode_seen_in   = tank_mode_seen_ff;
      tank_request_in     = tank_request_ff;
      float_high_ticks_in = float_high_ticks_ff;
      demand_ticks_in     = demand_ticks_ff;
      want                = 1'b0;
      demand              = 1'b0;
      others              = '0;
      unique case (req_kind_ff)
         KIND_TICK: begin
            // Tank step.
            if (req_lockout_ff || !tank_auto_mode_ff) begin
               tank_request_in = 1'b0;
               // A timing run already under way keeps counting.
               if (float_high_ticks_ff != '0) begin
                  float_high_ticks_in = sat_inc(float_high_ticks_ff);
               end
            end else begin
               if (req_float_high_ff) begin
                  want                = (float_high_ticks_ff >= float_stable_ticks_ff);
                  float_high_ticks_in = sat_inc(float_high_ticks_ff);
               end else begin
                  float_high_ticks_in = '0;
               end
               if ((relay_on_in & ZONE_MASK) != '0) begin
                  // Zone irrigation takes precedence over filling the tank.
                  if (relay_on_in[TANK_BIT]) begin
                     relay_on_in[PUMP_BIT] = 1'b0;
                     relay_on_in[TANK_BIT] = 1'b0;
                     pump_started_in       = 1'b0;
                     demand_latched_in     = 1'b0;
                  end
                  tank_request_in = 1'b0;
               end else begin
                  tank_request_in = want;
               end
            end
            // Pump step.
            demand = ((relay_on_in & ZONE_MASK) != '0) ||
                     (!tank_auto_mode_ff && relay_on_in[TANK_BIT]);
            if (tank_request_in) begin
               demand = 1'b1;
               if (!tank_mode_seen_in) begin
                  pump_started_in   = 1'b0;
                  demand_latched_in = 1'b0;
                  tank_mode_seen_in = 1'b1;
               end
               relay_on_in[TANK_BIT] = 1'b1;
            end else begin
               tank_mode_seen_in = 1'b0;
               if (tank_auto_mode_ff) begin
                  relay_on_in[TANK_BIT] = 1'b0;
               end
            end
            if (demand && !demand_latched_in) begin
               demand_ticks_in   = '0;
               demand_latched_in = 1'b1;
            end
            if (demand && !pump_started_in && (demand_ticks_in >= pump_start_delay_ff)) begin
               relay_on_in[PUMP_BIT] = 1'b1;
               pump_started_in       = 1'b1;
            end
            if (!demand) begin
               demand_latched_in = 1'b0;
               if (pump_started_in) begin
                  relay_on_in[PUMP_BIT] = 1'b0;
                  pump_started_in       = 1'b0;
                  demand_ticks_in       = '0;
               end
            end
            demand_ticks_in = sat_inc(demand_ticks_in);
         end
         KIND_TOGGLE: begin
            if (relay_on_ff[req_relay_index_ff]) begin
               others = relay_on_ff;
               others[PUMP_BIT] = 1'b0;
               others[req_relay_index_ff] = 1'b0;
               // Switching off the last valve also stops the pump.
               if (others == '0) begin
                  relay_on_in[PUMP_BIT] = 1'b0;
               end
               relay_on_in[req_relay_index_ff] = 1'b0;
            end else begin
               relay_on_in[req_relay_index_ff] = 1'b1;
            end
         end
         KIND_ALL_OFF: begin
            relay_on_in = '0;
         end
         KIND_UNUSED: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tank_auto_mode_ff     <= 1'b0;
         pump_start_delay_ff   <= PUMP_START_DELAY_RESET;
         float_stable_ticks_ff <= FLOAT_STABLE_TICKS_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_TANK_AUTO_MODE:     tank_auto_mode_ff     <= csr_wdata[0];
            CSR_PUMP_START_DELAY:   pump_start_delay_ff   <= csr_wdata;
            CSR_FLOAT_STABLE_TICKS: float_stable_ticks_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff        <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         relay_on_ff         <= '0;
         pump_started_ff     <= 1'b0;
         demand_latched_ff   <= 1'b0;
         tank_mode_seen_ff   <= 1'b0;
         tank_request_ff     <= 1'b0;
         float_high_ticks_ff <= '0;
         demand_ticks_ff     <= '0;
      end else begin
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff        <= 1'b1;
            relay_on_ff         <= relay_on_in;
            pump_started_ff     <= pump_started_in;
            demand_latched_ff   <= demand_latched_in;
            tank_mode_seen_ff   <= tank_mode_seen_in;
            tank_request_ff     <= tank_request_in;
            float_high_ticks_ff <= float_high_ticks_in;
            demand_ticks_ff     <= demand_ticks_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         req_kind_ff        <= req_kind;
         req_relay_index_ff <= req_relay_index;
         req_float_high_ff  <= req_float_high;
         req_lockout_ff     <= req_lockout;
      end
      if (advance) begin
         rsp_relay_states_ff     <= relay_on_in;
         rsp_pump_running_ff     <= pump_started_in;
         rsp_tank_wants_water_ff <= tank_request_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_relay_states     = rsp_relay_states_ff;
   assign rsp_pump_running     = rsp_pump_running_ff;
   assign rsp_tank_wants_water = rsp_tank_wants_water_ff;

   // A started pump always belongs to a latched demand period.
   `PTRC_ASSERT_SAME(a_started_implies_latched, clock, reset, pump_started_ff, demand_latched_ff)
   // A request that moves into the response stage always shows up as a response.
   `PTRC_ASSERT_NEXT(a_advance_gives_response, clock, reset, advance, rsp_valid_ff)
   // A held request is never dropped while the response stage is blocked.
   `PTRC_ASSERT_NEXT(a_blocked_request_holds, clock, reset, req_valid_ff && !advance, req_valid_ff)

endmodule
